// ===== design/bpc_pkg.sv =====
`default_nettype none
package bpc_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int BTN_W       = 3;
	localparam int TIME_W      = 32;
	localparam int LIMIT_W     = 16;
	localparam int LOCK_W      = 9;
	localparam int MASK_W      = 8;
	localparam int COUNT_W     = 16;
	localparam int STATUS_W    = 3;
	localparam int BEEP_W      = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd1000;
	localparam logic [LIMIT_W-1:0] KEEP_LIMIT_RST   = 16'd5000;
	localparam logic [LIMIT_W-1:0] REPEAT_IVL_RST   = 16'd500;
	localparam logic [LOCK_W-1:0]  LOCK_POLLS_RST   = 9'd300;
	localparam logic [MASK_W-1:0]  INVERT_MASK_RST  = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LONG_LIMIT  = 3'd0,
		REG_KEEP_LIMIT  = 3'd1,
		REG_REPEAT_IVL  = 3'd2,
		REG_LOCK_POLLS  = 3'd3,
		REG_INVERT_MASK = 3'd4
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE      = 3'd0,
		ST_SHORT     = 3'd1,
		ST_LONG      = 3'd2,
		ST_KEEP_LONG = 3'd3,
		ST_REPEAT    = 3'd4
	} status_t;

	typedef enum logic [BEEP_W-1:0] {
		BEEP_NONE  = 2'd0,
		BEEP_SHORT = 2'd1,
		BEEP_LONG  = 2'd2,
		BEEP_FOUR  = 2'd3
	} beep_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] long_limit;
		logic [LIMIT_W-1:0] keep_limit;
		logic [LIMIT_W-1:0] repeat_ivl;
		logic [LOCK_W-1:0]  lock_polls;
		logic [MASK_W-1:0]  invert_mask;
	} cfg_t;

	typedef struct packed {
		logic               last_pressed;
		logic [TIME_W-1:0]  press_start;
		logic [TIME_W-1:0]  repeat_mark;
		logic [COUNT_W-1:0] repeat_cnt;
		status_t            status;
		logic [LOCK_W-1:0]  lock_cnt;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		status_t            status;
		logic [COUNT_W-1:0] repeat_cnt;
		beep_t              beep;
	} res_t;

endpackage
`default_nettype wire

// ===== design/bpc_if.sv =====
`default_nettype none
interface poll_if import bpc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BTN_W-1:0]  button_index;
	logic              raw_level;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, button_index, raw_level, time_ms, input ready);
	modport sink   (input valid, button_index, raw_level, time_ms, output ready);
endinterface

interface result_if import bpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BTN_W-1:0]    button_out;
	logic [STATUS_W-1:0] press_status;
	logic [COUNT_W-1:0]  repeat_count;
	logic [BEEP_W-1:0]   beep_code;

	modport source (output valid, button_out, press_status, repeat_count, beep_code,
		input ready);
	modport sink   (input valid, button_out, press_status, repeat_count, beep_code,
		output ready);
endinterface

interface cfg_if import bpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/button_press_classifier.sv =====
`default_nettype none
// channel   dir   words
// poll      in    button_index, raw_level, time_ms
// result    out   button_out, press_status, repeat_count, beep_code
// cfg       in    index, data (always ready)
//
// One poll per cycle while results are taken; each poll passes the update stage
// and the output register. Per-button state sits in a RAM with registered read:
// read on accept, update and write back as that stage advances, with the last
// write forwarded to a following poll of the same button. Reset clears per-entry
// valid bits, so an unwritten entry reads as all zero; no clearing pass. A stalled
// result holds the update stage; poll.ready drops only while both stages are full.
module button_press_classifier import bpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	poll_if.sink      poll,
	result_if.source  result,
	cfg_if.sink       cfg
);
	cfg_t               regs;
	logic               poll_acc;
	logic               s1_adv;
	logic               s1_in_range;
	logic               wr_en;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             cur;
	entry_t             nxt;
	res_t               res;

	logic               s1_valid_q;
	logic [BTN_W-1:0]   idx_s1;
	logic               level_s1;
	logic [TIME_W-1:0]  time_s1;
	logic               vld_s1;

	logic [NUM_BUTTONS-1:0] vld_q;
	logic               fwd_valid_q;
	logic [BTN_W-1:0]   fwd_idx_q;
	entry_t             fwd_data_q;

	logic               out_valid_q;
	logic [BTN_W-1:0]   out_btn_q;
	res_t               out_res_q;

	bpc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bpc_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BUTTONS)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (idx_s1),
		.wdata (nxt),
		.re    (poll_acc),
		.raddr (poll.button_index),
		.rdata (rd_data)
	);

	bpc_update u_update (
		.regs  (regs),
		.cur   (cur),
		.idx   (idx_s1),
		.level (level_s1),
		.now   (time_s1),
		.nxt   (nxt),
		.res   (res)
	);

	assign s1_adv      = s1_valid_q && (!out_valid_q || result.ready);
	assign poll.ready  = !s1_valid_q || s1_adv;
	assign poll_acc    = poll.valid && poll.ready;
	assign s1_in_range = 32'(idx_s1) < NUM_BUTTONS;
	assign wr_en       = s1_adv && s1_in_range;

	// newest write wins over the RAM word read in the same cycle
	always_comb begin
		if (fwd_valid_q && fwd_idx_q == idx_s1) begin
			cur = fwd_data_q;
		end else if (vld_s1) begin
			cur = entry_t'(rd_data);
		end else begin
			cur = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_valid_q <= 1'b0;
			vld_q       <= '0;
		end else begin
			if (poll_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				fwd_valid_q   <= 1'b1;
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_acc) begin
			idx_s1   <= poll.button_index;
			level_s1 <= poll.raw_level;
			time_s1  <= poll.time_ms;
			vld_s1   <= vld_q[poll.button_index];
		end
		if (wr_en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= nxt;
		end
		if (s1_adv) begin
			out_btn_q <= idx_s1;
			if (s1_in_range) begin
				out_res_q <= res;
			end else begin
				out_res_q <= '0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.button_out   = out_btn_q;
	assign result.press_status = out_res_q.status;
	assign result.repeat_count = out_res_q.repeat_cnt;
	assign result.beep_code    = out_res_q.beep;
endmodule
`default_nettype wire

// ===== design/bpc_ram.sv =====
`default_nettype none
module bpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WIDTH-1:0]     wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WIDTH-1:0]     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/bpc_cfg.sv =====
`default_nettype none
module bpc_cfg import bpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	cfg_if.sink       cfg,
	output cfg_t      regs
);
	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.long_limit  <= LONG_LIMIT_RST;
			regs_q.keep_limit  <= KEEP_LIMIT_RST;
			regs_q.repeat_ivl  <= REPEAT_IVL_RST;
			regs_q.lock_polls  <= LOCK_POLLS_RST;
			regs_q.invert_mask <= INVERT_MASK_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LONG_LIMIT:  regs_q.long_limit  <= cfg.data;
				REG_KEEP_LIMIT:  regs_q.keep_limit  <= cfg.data;
				REG_REPEAT_IVL:  regs_q.repeat_ivl  <= cfg.data;
				REG_LOCK_POLLS:  regs_q.lock_polls  <= cfg.data[LOCK_W-1:0];
				REG_INVERT_MASK: regs_q.invert_mask <= cfg.data[MASK_W-1:0];
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/bpc_update.sv =====
`default_nettype none
module bpc_update import bpc_pkg::*; (
	input  wire cfg_t               regs,
	input  wire entry_t             cur,
	input  wire logic [BTN_W-1:0]   idx,
	input  wire logic               level,
	input  wire logic [TIME_W-1:0]  now,
	output entry_t                  nxt,
	output res_t                    res
);
	logic               pressed;
	logic [TIME_W-1:0]  since_start;
	logic [TIME_W-1:0]  since_mark;
	logic [LOCK_W-1:0]  lock_inc;
	entry_t             mid;
	beep_t              beep;

	assign pressed     = regs.invert_mask[idx] ? level : ~level;
	assign since_start = now - cur.press_start;
	assign since_mark  = now - cur.repeat_mark;
	assign lock_inc    = mid.lock_cnt + LOCK_W'(1);

	always_comb begin
		mid  = cur;
		beep = BEEP_NONE;
		if (pressed) begin
			if (!cur.last_pressed) begin
				mid.press_start = now;
				mid.repeat_mark = now;
				mid.repeat_cnt  = '0;
			end else if (since_start > TIME_W'(regs.keep_limit)) begin
				// past keep-long: hold without repeats
			end else if (since_mark > TIME_W'(regs.repeat_ivl)) begin
				mid.repeat_mark = now;
				mid.status      = ST_REPEAT;
				mid.repeat_cnt  = cur.repeat_cnt + COUNT_W'(1);
			end
		end else if (cur.last_pressed) begin
			if (since_start > TIME_W'(regs.keep_limit)) begin
				mid.status = ST_KEEP_LONG;
				beep       = BEEP_FOUR;
			end else if (since_start > TIME_W'(regs.long_limit)) begin
				mid.status = ST_LONG;
				beep       = BEEP_LONG;
			end else begin
				mid.status = ST_SHORT;
				beep       = BEEP_SHORT;
			end
			mid.lock_cnt = '0;
		end
		mid.last_pressed = pressed;
	end

	always_comb begin
		nxt = mid;
		if (mid.status == ST_LONG || mid.status == ST_SHORT) begin
			if (lock_inc >= regs.lock_polls) begin
				nxt.status   = ST_NONE;
				nxt.lock_cnt = '0;
			end else begin
				nxt.lock_cnt = lock_inc;
			end
		end
		res.status     = nxt.status;
		res.repeat_cnt = nxt.repeat_cnt;
		res.beep       = beep;
	end
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bpc_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_POLLS = 1100;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

	// sel is the button for a poll row and the register index for a config row
	typedef struct packed {
		row_kind_t           kind;
		logic [2:0]          sel;
		logic                lvl;
		logic [31:0]         val;
		logic                typed;
		status_t             st;
		logic [COUNT_W-1:0]  cnt;
		beep_t               bp;
	} row_t;

	typedef struct packed {
		logic [BTN_W-1:0]   button;
		status_t            status;
		logic [COUNT_W-1:0] count;
		beep_t              beep;
	} outcome_t;

	localparam int PLAN_LEN = 32;
	localparam row_t PLAN [PLAN_LEN] = '{
		'{ROW_POLL, 3'd0, 1'b0, 32'h0000_0000, 1'b1, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd0, 1'b1, 32'h0000_0064, 1'b1, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd0, 1'b1, 32'h0000_0259, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd0, 1'b1, 32'h0000_044D, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd0, 1'b0, 32'h0000_044D, 1'b1, ST_LONG, 16'd1, BEEP_LONG},
		'{ROW_POLL, 3'd0, 1'b0, 32'h0000_04B0, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		// press and release across the time wrap
		'{ROW_POLL, 3'd7, 1'b0, 32'hFFFF_FFF0, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd7, 1'b1, 32'h0000_0010, 1'b1, ST_SHORT, 16'd0, BEEP_SHORT},
		'{ROW_POLL, 3'd3, 1'b0, 32'hFFFF_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd3, 1'b0, 32'hFFFF_1770, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd3, 1'b1, 32'hFFFF_1771, 1'b1, ST_KEEP_LONG, 16'd0, BEEP_FOUR},
		// new press keeps the keep-long status
		'{ROW_POLL, 3'd3, 1'b0, 32'hFFFF_2000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_LONG_LIMIT, 1'b0, 32'h0000_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_KEEP_LIMIT, 1'b0, 32'h0000_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_REPEAT_IVL, 1'b0, 32'h0000_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		// lock of zero, upper data bits dropped
		'{ROW_CFG, REG_LOCK_POLLS, 1'b0, 32'h0000_FE00, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_INVERT_MASK, 1'b0, 32'h0000_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_SPARE, 1'b0, 32'h0000_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd5, 1'b1, 32'h0000_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd5, 1'b1, 32'h0000_0001, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd5, 1'b0, 32'h0000_0001, 1'b1, ST_NONE, 16'd1, BEEP_LONG},
		'{ROW_POLL, 3'd5, 1'b0, 32'h0000_0002, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_LONG_LIMIT, 1'b0, 32'h0000_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_KEEP_LIMIT, 1'b0, 32'h0000_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_REPEAT_IVL, 1'b0, 32'h0000_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_LOCK_POLLS, 1'b0, 32'h0000_FE01, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_CFG, REG_INVERT_MASK, 1'b0, 32'h0000_FF00, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd2, 1'b0, 32'hFFFF_FFFF, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd2, 1'b0, 32'h0000_0000, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd2, 1'b1, 32'h0000_0000, 1'b1, ST_KEEP_LONG, 16'd0, BEEP_FOUR},
		'{ROW_POLL, 3'd2, 1'b0, 32'h0000_0005, 1'b0, ST_NONE, 16'd0, BEEP_NONE},
		'{ROW_POLL, 3'd2, 1'b1, 32'h0000_0005, 1'b1, ST_NONE, 16'd0, BEEP_SHORT}
	};

	logic clk;
	logic arst_n;

	poll_if   poll ();
	result_if result ();
	cfg_if    cfg ();

	button_press_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll),
		.result (result),
		.cfg    (cfg)
	);

	// predictor copy of the registers and per-button state
	logic [LIMIT_W-1:0] long_ms;
	logic [LIMIT_W-1:0] keep_ms;
	logic [LIMIT_W-1:0] ivl_ms;
	logic [LOCK_W-1:0]  lock_len;
	logic [MASK_W-1:0]  hi_pressed;

	logic               was_down [NUM_BUTTONS];
	logic [TIME_W-1:0]  down_at [NUM_BUTTONS];
	logic [TIME_W-1:0]  mark_at [NUM_BUTTONS];
	logic [COUNT_W-1:0] repeats [NUM_BUTTONS];
	status_t            state_of [NUM_BUTTONS];
	logic [LOCK_W-1:0]  lock_run [NUM_BUTTONS];

	outcome_t outcomes_due [$];
	int       errors = 0;
	int       polls_sent = 0;
	int       cycles = 0;
	bit       calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= 60)
			$display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	function automatic outcome_t classify_poll(input logic [BTN_W-1:0] b, input logic lvl,
			input logic [TIME_W-1:0] t);
		outcome_t          o;
		logic              down;
		logic [TIME_W-1:0] held;
		logic [TIME_W-1:0] since_mark;
		o.button = b;
		o.beep = BEEP_NONE;
		down = hi_pressed[b] ? lvl : !lvl;
		held = t - down_at[b];
		since_mark = t - mark_at[b];
		if (down) begin
			if (!was_down[b]) begin
				down_at[b] = t;
				mark_at[b] = t;
				repeats[b] = '0;
			end else if (held <= {16'd0, keep_ms} && since_mark > {16'd0, ivl_ms}) begin
				mark_at[b] = t;
				state_of[b] = ST_REPEAT;
				repeats[b] = repeats[b] + COUNT_W'(1);
			end
		end else if (was_down[b]) begin
			if (held > {16'd0, keep_ms}) begin
				state_of[b] = ST_KEEP_LONG;
				o.beep = BEEP_FOUR;
			end else if (held > {16'd0, long_ms}) begin
				state_of[b] = ST_LONG;
				o.beep = BEEP_LONG;
			end else begin
				state_of[b] = ST_SHORT;
				o.beep = BEEP_SHORT;
			end
			lock_run[b] = '0;
		end
		was_down[b] = down;
		if (state_of[b] == ST_LONG || state_of[b] == ST_SHORT) begin
			lock_run[b] = lock_run[b] + LOCK_W'(1);
			if (lock_run[b] >= lock_len) begin
				state_of[b] = ST_NONE;
				lock_run[b] = '0;
			end
		end
		o.status = state_of[b];
		o.count = repeats[b];
		return o;
	endfunction

	// drain: hold polls until every result is back
	task automatic settle();
		poll.valid <= 1'b0;
		do @(posedge clk); while (outcomes_due.size() != 0);
	endtask

	// leaves cfg.valid high; the caller drops it after the last write
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_LONG_LIMIT:  long_ms = data;
			REG_KEEP_LIMIT:  keep_ms = data;
			REG_REPEAT_IVL:  ivl_ms = data;
			REG_LOCK_POLLS:  lock_len = data[LOCK_W-1:0];
			REG_INVERT_MASK: hi_pressed = data[MASK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic offer_poll(input logic [BTN_W-1:0] b, input logic lvl,
			input logic [TIME_W-1:0] t);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(7) == 0)
			gap = $urandom_range(11, 1);
		if (gap != 0) begin
			poll.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll.valid <= 1'b1;
		poll.button_index <= b;
		poll.raw_level <= lvl;
		poll.time_ms <= t;
		do @(posedge clk); while (!poll.ready);
	endtask

	task automatic poll_once(input logic [BTN_W-1:0] b, input logic lvl,
			input logic [TIME_W-1:0] t);
		offer_poll(b, lvl, t);
		outcomes_due.push_back(classify_poll(b, lvl, t));
		polls_sent++;
	endtask

	function automatic logic [LIMIT_W-1:0] pick_limit();
		case ($urandom_range(5))
			0: pick_limit = '0;
			1: pick_limit = '1;
			2: pick_limit = LIMIT_W'($urandom);
			default: pick_limit = LIMIT_W'($urandom_range(3000));
		endcase
	endfunction

	task automatic retune();
		logic [CFG_DATA_W-1:0] lock_word;
		settle();
		case ($urandom_range(5))
			0: lock_word = 16'd511;
			1: lock_word = CFG_DATA_W'($urandom);
			2: lock_word = 16'd300;
			default: lock_word = CFG_DATA_W'($urandom_range(8));
		endcase
		cfg_write(REG_LONG_LIMIT, pick_limit());
		cfg_write(REG_KEEP_LIMIT, pick_limit());
		cfg_write(REG_REPEAT_IVL,
			$urandom_range(1) ? pick_limit() : CFG_DATA_W'($urandom_range(400)));
		cfg_write(REG_LOCK_POLLS, lock_word);
		cfg_write(REG_INVERT_MASK, CFG_DATA_W'($urandom));
		if ($urandom_range(2) == 0)
			cfg_write(CFG_IDX_W'($urandom_range(REG_SPARE, REG_FIRST_SPARE)),
				CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// press; held polls mostly near the interval; release often near a limit; idle polls
	task automatic press_run();
		logic [BTN_W-1:0]  b;
		logic              on;
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t;
		int                tail;
		b = BTN_W'($urandom_range(NUM_BUTTONS - 1));
		on = hi_pressed[b];
		t0 = $urandom;
		if ($urandom_range(1))
			poll_once(b, !on, t0 - $urandom_range(50));
		poll_once(b, on, t0);
		t = t0;
		repeat ($urandom_range(6)) begin
			case ($urandom_range(3))
				0: t += TIME_W'(ivl_ms);
				1: t += TIME_W'(ivl_ms) + 1;
				2: t += $urandom_range(2 * ivl_ms + 2);
				default: t += $urandom_range(keep_ms + 2);
			endcase
			poll_once(b, on, t);
		end
		case ($urandom_range(5))
			0: t = t0 + TIME_W'(long_ms);
			1: t = t0 + TIME_W'(long_ms) + 1;
			2: t = t0 + TIME_W'(keep_ms);
			3: t = t0 + TIME_W'(keep_ms) + 1;
			default: t += $urandom_range(ivl_ms + 1);
		endcase
		poll_once(b, !on, t);
		tail = $urandom_range(lock_len > 12 ? 3 : lock_len + 1);
		repeat (tail) begin
			t += $urandom_range(20);
			poll_once(b, !on, t);
		end
	endtask

	always @(posedge clk) begin : watch_results
		outcome_t o;
		if (arst_n && result.valid && result.ready) begin
			if (outcomes_due.size() == 0) begin
				report_mismatch("result with no poll, button", 32'(result.button_out), '0);
			end else begin
				o = outcomes_due.pop_front();
				if (result.button_out !== o.button)
					report_mismatch("button_out", 32'(result.button_out), 32'(o.button));
				if (result.press_status !== o.status)
					report_mismatch("press_status", 32'(result.press_status),
						32'(o.status));
				if (result.repeat_count !== o.count)
					report_mismatch("repeat_count", 32'(result.repeat_count),
						32'(o.count));
				if (result.beep_code !== o.beep)
					report_mismatch("beep_code", 32'(result.beep_code), 32'(o.beep));
			end
		end
	end

	initial begin
		result.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(3) == 0) begin
				result.ready <= 1'b0;
				repeat ($urandom_range(11, 1)) @(posedge clk);
			end
			result.ready <= 1'b1;
			repeat ($urandom_range(24, 1)) @(posedge clk);
		end
	end

	initial begin
		outcome_t o;
		bit       in_cfg;
		int       base;
		int       next_tune;
		arst_n <= 1'b0;
		poll.valid <= 1'b0;
		poll.button_index <= '0;
		poll.raw_level <= 1'b0;
		poll.time_ms <= '0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_LONG_LIMIT;
		cfg.data <= '0;
		long_ms = LONG_LIMIT_RST;
		keep_ms = KEEP_LIMIT_RST;
		ivl_ms = REPEAT_IVL_RST;
		lock_len = LOCK_POLLS_RST;
		hi_pressed = INVERT_MASK_RST;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			was_down[i] = 1'b0;
			down_at[i] = '0;
			mark_at[i] = '0;
			repeats[i] = '0;
			state_of[i] = ST_NONE;
			lock_run[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_cfg = 1'b0;
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				if (!in_cfg)
					settle();
				cfg_write(PLAN[i].sel, PLAN[i].val[CFG_DATA_W-1:0]);
				in_cfg = 1'b1;
			end else begin
				if (in_cfg) begin
					cfg.valid <= 1'b0;
					in_cfg = 1'b0;
				end
				offer_poll(PLAN[i].sel, PLAN[i].lvl, PLAN[i].val);
				o = classify_poll(PLAN[i].sel, PLAN[i].lvl, PLAN[i].val);
				if (PLAN[i].typed) begin
					o.status = PLAN[i].st;
					o.count = PLAN[i].cnt;
					o.beep = PLAN[i].bp;
				end
				outcomes_due.push_back(o);
				polls_sent++;
			end
		end

		base = polls_sent;
		next_tune = base;
		while (polls_sent - base < RANDOM_POLLS) begin
			if (!calm && polls_sent >= next_tune) begin
				retune();
				next_tune = polls_sent + $urandom_range(200, 80);
			end
			if (polls_sent - base > RANDOM_POLLS - 150)
				calm = 1'b1;
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(6, 1))
					poll_once(BTN_W'($urandom_range(NUM_BUTTONS - 1)),
						1'($urandom_range(1)), $urandom);
			end else begin
				press_run();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
